// ----- rtl/rar_pkg.sv -----
// shared types and constants for the rational arithmetic reducer
package rar_pkg;

  localparam int OperandWidthDefault = 16;
  localparam int OpWidth = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_GCD,
    BK_DIVN,
    BK_DIVD,
    BK_OUT
  } bk_state_t;

endpackage

// ----- rtl/rar_if.sv -----
// valid/ready channel interface
interface rar_if #(
  parameter int W = 16
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/rar_front.sv -----
// front end: forms the cross products, sign and error flag of one request
module rar_front #(
  parameter int OW = rar_pkg::OperandWidthDefault
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_operation,
  input  logic [OW-1:0]   in_a_num,
  input  logic [OW-1:0]   in_a_den,
  input  logic [OW-1:0]   in_b_num,
  input  logic [OW-1:0]   in_b_den,
  output logic            q_valid,
  input  logic            q_ready,
  output logic [2*OW-1:0] q_mag,
  output logic [2*OW-1:0] q_den,
  output logic            q_neg,
  output logic            q_err
);
  import rar_pkg::*;

  localparam int PW = 2 * OW;

  // stage 1: products registered
  logic          s1_valid_r, s1_valid_nxt;
  logic [1:0]    s1_op_r;
  logic          s1_an_r, s1_bn_r, s1_bz_r;
  logic [PW-1:0] s1_p_r, s1_q_r, s1_d_r;
  logic [PW-1:0] s1_p_nxt, s1_q_nxt, s1_d_nxt;

  logic          an, bn;
  logic [OW-1:0] am, bm;
  logic          s1_adv;

  // stage 2: queue entry
  logic          q_valid_r;
  logic [PW-1:0] q_mag_r, q_mag_nxt, q_den_r;
  logic          q_neg_r, q_neg_nxt, q_err_r;

  assign an = in_a_num[OW-1];
  assign bn = in_b_num[OW-1];
  assign am = an ? (~in_a_num + 1'b1) : in_a_num;
  assign bm = bn ? (~in_b_num + 1'b1) : in_b_num;

  assign s1_adv   = !q_valid_r || q_ready;
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_p_nxt = '0;
    s1_q_nxt = '0;
    s1_d_nxt = '0;
    unique case (op_t'(in_operation))
      OP_ADD, OP_SUB: begin
        s1_p_nxt = PW'(am) * PW'(in_b_den);
        s1_q_nxt = PW'(in_a_den) * PW'(bm);
        s1_d_nxt = PW'(in_a_den) * PW'(in_b_den);
      end
      OP_MUL: begin
        s1_p_nxt = PW'(am) * PW'(bm);
        s1_d_nxt = PW'(in_a_den) * PW'(in_b_den);
      end
      default: begin
        s1_p_nxt = PW'(am) * PW'(in_b_den);
        s1_d_nxt = PW'(in_a_den) * PW'(bm);
      end
    endcase
    if (in_valid && in_ready) s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else s1_valid_r <= s1_valid_nxt;
    if (in_valid && in_ready) begin
      s1_op_r <= in_operation;
      s1_an_r <= an;
      s1_bn_r <= bn;
      s1_bz_r <= (bm == '0);
      s1_p_r  <= s1_p_nxt;
      s1_q_r  <= s1_q_nxt;
      s1_d_r  <= s1_d_nxt;
    end
  end

  // signed combine of the two cross products for add/sub; mul and div pass the first product with the xor of the signs
  always_comb begin
    logic qs;
    qs = (op_t'(s1_op_r) == OP_SUB) ? !s1_bn_r : s1_bn_r;
    q_mag_nxt = s1_p_r;
    q_neg_nxt = s1_an_r ^ s1_bn_r;
    unique case (op_t'(s1_op_r))
      OP_ADD, OP_SUB: begin
        if (s1_an_r == qs) begin
          q_mag_nxt = s1_p_r + s1_q_r;
          q_neg_nxt = s1_an_r;
        end else if (s1_p_r >= s1_q_r) begin
          q_mag_nxt = s1_p_r - s1_q_r;
          q_neg_nxt = s1_an_r;
        end else begin
          q_mag_nxt = s1_q_r - s1_p_r;
          q_neg_nxt = qs;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) q_valid_r <= 1'b0;
    else if (s1_adv) q_valid_r <= s1_valid_r;
    if (s1_adv && s1_valid_r) begin
      q_mag_r <= q_mag_nxt;
      q_den_r <= s1_d_r;
      q_neg_r <= q_neg_nxt;
      q_err_r <= (op_t'(s1_op_r) == OP_DIV) && s1_bz_r;
    end
  end

  assign q_valid = q_valid_r;
  assign q_mag   = q_mag_r;
  assign q_den   = q_den_r;
  assign q_neg   = q_neg_r;
  assign q_err   = q_err_r;

  // a zero divisor leaves a zero cross denominator
  a_err_div: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid_r && q_err_r |-> q_den_r == '0)
    else $error("err flag");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid_r && !q_ready |=> q_valid_r && $stable(q_mag_r))
    else $error("queue entry lost");
  a_s1: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r)
    else $error("stage one lost");
endmodule

// ----- rtl/rar_back.sv -----
// back end: euclid gcd by subtract-shift remainder, then two restoring divides
module rar_back #(
  parameter int OW = rar_pkg::OperandWidthDefault
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  logic [2*OW-1:0] q_mag,
  input  logic [2*OW-1:0] q_den,
  input  logic            q_neg,
  input  logic            q_err,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2*OW:0]   out_res_num,
  output logic [2*OW-1:0] out_res_den,
  output logic            out_div_zero
);
  import rar_pkg::*;

  localparam int PW = 2 * OW;
  localparam int CW = $clog2(PW + 1);

  bk_state_t     st_r, st_nxt;
  logic [PW-1:0] mag_r, mag_nxt, den_r, den_nxt;
  logic          neg_r, neg_nxt, err_r, err_nxt;
  logic [PW-1:0] x_r, x_nxt, y_r, y_nxt;    // euclid pair
  logic [PW-1:0] rem_r, rem_nxt;            // remainder / quotient work
  logic [PW-1:0] quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] nres_r, nres_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [PW:0]   trial;
  logic [PW-1:0] dsr;

  // one restoring-division bit per cycle; dividend in quo_r, partial rem in rem_r
  assign trial = {rem_r, quo_r[PW-1]} - {1'b0, dsr};
  assign dsr   = (st_r == BK_GCD) ? y_r : x_r;

  always_comb begin
    st_nxt = st_r;
    mag_nxt = mag_r; den_nxt = den_r; neg_nxt = neg_r; err_nxt = err_r;
    x_nxt = x_r; y_nxt = y_r; rem_nxt = rem_r; quo_nxt = quo_r;
    cnt_nxt = cnt_r; nres_nxt = nres_r;
    out_valid_nxt = out_valid_r;
    q_ready = 1'b0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (st_r)
      BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          mag_nxt = q_mag; den_nxt = q_den; neg_nxt = q_neg; err_nxt = q_err;
          x_nxt = q_mag; y_nxt = q_den;
          rem_nxt = '0; quo_nxt = q_mag; cnt_nxt = CW'(PW);
          if (q_err) begin
            mag_nxt = '0; den_nxt = '0; st_nxt = BK_OUT;
          end else if (q_den == '0) begin
            x_nxt = q_mag; st_nxt = BK_DIVN;
            rem_nxt = '0; quo_nxt = q_mag;
          end else begin
            st_nxt = BK_GCD;
          end
        end
      end
      BK_GCD: begin
        // compute x mod y, one bit a cycle
        if (!trial[PW]) rem_nxt = trial[PW-1:0];
        else rem_nxt = {rem_r[PW-2:0], quo_r[PW-1]};
        quo_nxt = {quo_r[PW-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          x_nxt = y_r;
          y_nxt = rem_nxt;
          rem_nxt = '0; quo_nxt = y_r; cnt_nxt = CW'(PW);
          if (y_nxt == '0) begin
            // x_nxt = gcd
            st_nxt = BK_DIVN;
            quo_nxt = mag_r;
          end
        end
      end
      BK_DIVN, BK_DIVD: begin
        if (x_r == '0) begin
          st_nxt = BK_OUT;   // zero numerator over zero denominator
        end else begin
          if (!trial[PW]) rem_nxt = trial[PW-1:0];
          else rem_nxt = {rem_r[PW-2:0], quo_r[PW-1]};
          quo_nxt = {quo_r[PW-2:0], !trial[PW]};
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            rem_nxt = '0; cnt_nxt = CW'(PW);
            if (st_r == BK_DIVN) begin
              nres_nxt = quo_nxt; quo_nxt = den_r; st_nxt = BK_DIVD;
            end else begin
              mag_nxt = nres_r; den_nxt = quo_nxt; st_nxt = BK_OUT;
            end
          end
        end
      end
      default: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          st_nxt = BK_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r <= mag_nxt; den_r <= den_nxt; neg_r <= neg_nxt; err_r <= err_nxt;
    x_r <= x_nxt; y_r <= y_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt;
    cnt_r <= cnt_nxt; nres_r <= nres_nxt;
  end

  logic [PW:0] res_num_r;
  logic [PW-1:0] res_den_r;
  logic          res_err_r;
  logic [PW:0]   ext;
  assign ext = {1'b0, mag_r};
  always_ff @(posedge clk) begin
    if (st_r == BK_OUT && (!out_valid_r || out_ready)) begin
      res_num_r <= (neg_r && mag_r != '0) ? (~ext + 1'b1) : ext;
      res_den_r <= den_r;
      res_err_r <= err_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_res_num  = res_num_r;
  assign out_res_den  = res_den_r;
  assign out_div_zero = res_err_r;

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> st_r == BK_IDLE)
    else $error("ready outside idle");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_GCD) |-> cnt_r != '0 && y_r != '0)
    else $error("gcd divisor zero");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(res_num_r))
    else $error("result dropped");
endmodule

// ----- rtl/rational_arith_reduce_core.sv -----
// top level: rational add/sub/mul/div with gcd reduction
//  channel | direction | payload
//  in      | sink      | operation, a_num, a_den, b_num, b_den
//  out     | source    | res_num, res_den, div_zero
// front end takes a request each cycle, unless the back end holds its queue, into a two-stage product pipe and queue
// back end: gcd by euclid steps of subtract-shift remainder, then two divisions by the gcd
// the back end takes a new request only once it is done with the last; its divider gives one bit a cycle
// synchronous active-low reset clears all valid flags and the back-end state
module rational_arith_reduce_core #(
  parameter int OPERAND_WIDTH = rar_pkg::OperandWidthDefault
) (
  input  logic clk,
  input  logic rst_n,
  rar_if.sink   in_ch,
  rar_if.source out_ch
);
  import rar_pkg::*;

  localparam int OW = OPERAND_WIDTH;
  localparam int PW = 2 * OW;

  logic          q_valid, q_ready, q_neg, q_err;
  logic [PW-1:0] q_mag, q_den;

  rar_front #(.OW(OW)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_operation(in_ch.data[4*OW+1:4*OW]),
    .in_a_num(in_ch.data[4*OW-1:3*OW]),
    .in_a_den(in_ch.data[3*OW-1:2*OW]),
    .in_b_num(in_ch.data[2*OW-1:OW]),
    .in_b_den(in_ch.data[OW-1:0]),
    .q_valid, .q_ready, .q_mag, .q_den, .q_neg, .q_err
  );

  rar_back #(.OW(OW)) u_back (
    .clk, .rst_n,
    .q_valid, .q_ready, .q_mag, .q_den, .q_neg, .q_err,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_res_num(out_ch.data[4*OW+1:2*OW+1]),
    .out_res_den(out_ch.data[2*OW:1]),
    .out_div_zero(out_ch.data[0])
  );
endmodule

// ----- verif/tb_rational_arith_reduce_core.sv -----
// testbench for the rational arithmetic reducer: predicted results checked in order
`timescale 1ns / 1ps

module tb_rational_arith_reduce_core;
  import rar_pkg::*;

  localparam int W = 16;
  localparam int InW = OpWidth + 4 * W;
  localparam int OutW = (2 * W + 1) + 2 * W + 1;
  localparam int IdleLimit = 20000;
  localparam int DrainCycles = 2000;

  typedef struct packed {
    op_t          op;
    logic [W-1:0] a_num;
    logic [W-1:0] a_den;
    logic [W-1:0] b_num;
    logic [W-1:0] b_den;
  } frac_req_t;

  typedef struct packed {
    logic [2*W:0]   num;
    logic [2*W-1:0] den;
    logic           div_zero;
  } frac_res_t;

  logic clk;
  logic rst_n;
  rar_if #(.W(InW))  in_ch ();
  rar_if #(.W(OutW)) out_ch ();

  rational_arith_reduce_core #(.OPERAND_WIDTH(W)) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  frac_res_t expected_q[$];
  int        errors;
  int        idle_cycles;
  int        ready_gap;
  bit        stall_mode;

  initial clk = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic longint unsigned mag_of(logic [W-1:0] v);
    return v[W-1] ? longint'((~v) + 1'b1) & 64'hFFFF : longint'(v);
  endfunction

  // reduced sum/difference/product/quotient of two fractions
  function automatic frac_res_t reduce_fraction(frac_req_t r);
    longint unsigned am, bm, ad, bd, p, q, mag, den, g;
    bit an, bn, ps, qs, neg, err;
    frac_res_t res;
    am = mag_of(r.a_num);
    bm = mag_of(r.b_num);
    an = r.a_num[W-1];
    bn = r.b_num[W-1];
    ad = r.a_den;
    bd = r.b_den;
    neg = 0;
    err = 0;
    mag = 0;
    den = 0;
    case (r.op)
      OP_ADD, OP_SUB: begin
        p = am * bd;
        q = ad * bm;
        ps = an;
        qs = (r.op == OP_SUB) ? !bn : bn;
        if (ps == qs) begin
          mag = p + q;
          neg = ps;
        end else if (p >= q) begin
          mag = p - q;
          neg = ps;
        end else begin
          mag = q - p;
          neg = qs;
        end
        den = ad * bd;
      end
      OP_MUL: begin
        mag = am * bm;
        neg = an != bn;
        den = ad * bd;
      end
      default: begin
        if (bm == 0) begin
          err = 1;
        end else begin
          mag = am * bd;
          neg = an != bn;
          den = ad * bm;
        end
      end
    endcase
    if (!err) begin
      g = gcd_of(mag, den);
      if (g != 0) begin
        mag = mag / g;
        den = den / g;
      end
    end
    if (mag == 0) neg = 0;
    res.num = neg ? (~mag[2*W:0]) + 1'b1 : mag[2*W:0];
    res.den = den[2*W-1:0];
    res.div_zero = err;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_request(frac_req_t r);
    int gap;
    in_ch.data <= r;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(reduce_fraction(r));
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [W-1:0] rand_num(bit narrow);
    return narrow ? W'($signed($urandom_range(0, 40)) - 20) : W'($urandom);
  endfunction

  function automatic logic [W-1:0] rand_den(bit narrow);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return '0;
    return narrow ? W'($urandom_range(1, 30)) : W'($urandom_range(1, 65535));
  endfunction

  function automatic frac_req_t rand_request(bit narrow);
    frac_req_t r;
    r.op = op_t'($urandom_range(0, 3));
    r.a_num = rand_num(narrow);
    r.a_den = rand_den(narrow);
    r.b_num = ($urandom_range(0, 19) == 0) ? '0 : rand_num(narrow);
    r.b_den = rand_den(narrow);
    return r;
  endfunction

  task automatic send_frac(op_t op, logic [W-1:0] an, logic [W-1:0] ad,
                           logic [W-1:0] bn, logic [W-1:0] bd);
    send_request('{op, an, ad, bn, bd});
  endtask

  task automatic test_directed();
    send_frac(OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
    send_frac(OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
    send_frac(OP_MUL, 16'h8000, 16'd1, 16'h8000, 16'd1);
    send_frac(OP_DIV, 16'd3, 16'd4, 16'hFFFE, 16'd5);
    send_frac(OP_DIV, 16'd7, 16'd9, 16'd0, 16'd5);
    send_frac(OP_DIV, 16'd0, 16'd9, 16'd0, 16'd1);
    send_frac(OP_ADD, 16'd0, 16'd9, 16'd0, 16'd7);
    send_frac(OP_MUL, 16'd0, 16'hFFFF, 16'h8000, 16'hFFFF);
    send_frac(OP_ADD, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'hFFFF);
    send_frac(OP_SUB, 16'h8000, 16'hFFFF, 16'h7FFF, 16'hFFFF);
    send_frac(OP_MUL, 16'h7FFF, 16'd1, 16'h7FFF, 16'd1);
    send_frac(OP_DIV, 16'h8000, 16'd1, 16'hFFFF, 16'hFFFF);
    send_frac(OP_DIV, 16'h8000, 16'hFFFF, 16'h8000, 16'd1);
    // zero denominators, then signed sub and add cases
    send_frac(OP_ADD, 16'd5, 16'd0, 16'd3, 16'd4);
    send_frac(OP_MUL, 16'hFFFB, 16'd3, 16'd2, 16'd0);
    send_frac(OP_MUL, 16'd0, 16'd0, 16'd2, 16'd3);
    send_frac(OP_DIV, 16'd6, 16'd0, 16'hFFFF, 16'd2);
    send_frac(OP_SUB, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1);
    send_frac(OP_SUB, 16'd0, 16'd1, 16'h8000, 16'd3);
    send_frac(OP_ADD, 16'hFFFF, 16'd2, 16'd1, 16'd2);
  endtask

  task automatic test_random(int count, bit narrow);
    repeat (count) send_request(rand_request(narrow));
  endtask

  // hold the sender until every expected result is back, then send 20 narrow requests
  task automatic test_drain_pause();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    test_random(20, 1'b1);
  endtask

  // result side: check, then pick the next ready
  always @(posedge clk) begin
    frac_res_t got, exp_res;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      idle_cycles <= 0;
      ready_gap <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("tb_rational_arith_reduce_core failed");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_q.size() == 0) begin
          $error("result with no request pending: num %0h den %0h", got.num, got.den);
          errors++;
        end else begin
          exp_res = expected_q.pop_front();
          if (got.num !== exp_res.num) begin
            $error("res_num expected %0d got %0d", $signed(exp_res.num), $signed(got.num));
            errors++;
          end
          if (got.den !== exp_res.den) begin
            $error("res_den expected %0d got %0d", exp_res.den, got.den);
            errors++;
          end
          if (got.div_zero !== exp_res.div_zero) begin
            $error("div_zero expected %0b got %0b", exp_res.div_zero, got.div_zero);
            errors++;
          end
        end
      end
      if ($urandom_range(0, 199) == 0) stall_mode = !stall_mode;
      // low stretches of random length, mostly short
      if (ready_gap > 0) begin
        ready_gap <= ready_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (stall_mode && $urandom_range(0, 9) == 0) begin
        ready_gap <= pick_gap();
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    errors = 0;
    stall_mode = 1'b1;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(700, 1'b1);
    test_drain_pause();
    test_random(600, 1'b0);
    test_random(600, 1'b1);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_rational_arith_reduce_core passed");
    end else begin
      $display("tb_rational_arith_reduce_core failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rar_pkg.sv
rtl/rar_if.sv
rtl/rar_front.sv
rtl/rar_back.sv
rtl/rational_arith_reduce_core.sv
verif/tb_rational_arith_reduce_core.sv
